// File: design/aadc_pkg.sv
`default_nettype none

package aadc_pkg;

  // Field widths
  localparam int unsigned ChanW   = 3;
  localparam int unsigned SampleW = 12;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ShiftW  = 3;
  localparam int unsigned DbW     = 3;

  // Stream and register port widths
  localparam int unsigned TdataW  = 16;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Constants of the scheme
  localparam int unsigned CHANNELS_PER_BANK_DEF = 8;
  localparam int unsigned LEVEL_SCALE           = 4000;
  localparam logic [ShiftW-1:0] SHIFT_MAX       = 3'd4;
  localparam logic [DbW-1:0]    DEADBAND_MAX    = 3'd5;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_AVG_SHIFT      = 1'b0,
    REG_DEADBAND_WIDTH = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ShiftW-1:0] avg_shift;
    logic [DbW-1:0]    deadband_width;
  } cfg_t;

  typedef struct packed {
    logic               bank;
    logic [ChanW-1:0]   channel;
    logic [SampleW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              bank;
    logic [ChanW-1:0]  channel;
    logic [LevelW-1:0] level;
  } result_t;

endpackage

`default_nettype wire

// File: design/adc_average_deadband_conditioner_top.sv
`default_nettype none

// Channel     Direction  Handshake                 Payload
// s_axis      in         tvalid / tready           tuser: source_bank; tdata: channel, sample
// m_axis      out        tvalid / tready           tuser: result_bank; tdata: channel, level
// apb         in         psel, penable / pready    paddr 0: avg_shift, 4: deadband_width
//
// Each item is held in the input register; the per-channel sum, count and held level are
// read, updated and written back as it leaves, so one item is taken per clock while the
// output register is free. The in-place read-modify-write of the channel state sets this figure.
// Reset clears the configuration, every channel's sum, count and held level, and both
// valid flags; no clearing pass is needed.
// A result waiting in the output register stalls the input register only while the
// downstream side holds tready low; items that complete no average still wait behind it.
module adc_average_deadband_conditioner_top #(
  parameter int unsigned ChannelsPerBank = aadc_pkg::CHANNELS_PER_BANK_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [aadc_pkg::TdataW-1:0]    s_axis_tdata,  // [2:0] channel_index,
                                                              // [14:3] raw_sample, [15] zero
  input  wire logic                           s_axis_tuser,  // [0] source_bank
  // Result stream
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [aadc_pkg::TdataW-1:0]    m_axis_tdata,  // [2:0] result_channel,
                                                              // [14:3] level, [15] zero
  output      logic                           m_axis_tuser,  // [0] result_bank
  // Configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [aadc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [aadc_pkg::ApbDataW-1:0]  pwdata,
  output      logic [aadc_pkg::ApbDataW-1:0]  prdata,
  output      logic                           pready
);

  aadc_pkg::cfg_t    cfg;
  aadc_pkg::item_t   item;
  aadc_pkg::result_t res;
  logic              item_valid;
  logic              out_free;
  logic              go;

  // Advance the held item whenever the output register can take whatever it yields
  assign go = item_valid && out_free;

  aadc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  aadc_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .go_i          (go),
    .valid_o       (item_valid),
    .item_o        (item)
  );

  aadc_chan_core #(
    .ChannelsPerBank (ChannelsPerBank)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (go),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  aadc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (go && res.valid),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Hold the input register while an untaken result blocks the output
  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !go)
    else $error("input register advanced over a stalled result");

  // A level never exceeds the full-scale value
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:3] <= 12'd4000))
    else $error("level above full scale");

  // An item that completes no average leaves the output register untouched
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && !res.valid) |=> (m_axis_tvalid == $past(m_axis_tvalid && !m_axis_tready)))
    else $error("result produced without a completed average");

endmodule

`default_nettype wire

// File: design/aadc_cfg_regs.sv
`default_nettype none

module aadc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [aadc_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [aadc_pkg::ApbDataW-1:0]  pwdata,
  output      logic [aadc_pkg::ApbDataW-1:0]  prdata,
  output      logic                           pready,
  output      aadc_pkg::cfg_t                 cfg_o
);

  aadc_pkg::cfg_t   cfg_q, cfg_d;
  aadc_pkg::reg_idx_e reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = aadc_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d  = cfg_q;
    prdata = '0;
    unique case (reg_sel)
      aadc_pkg::REG_AVG_SHIFT: begin
        prdata = {{(aadc_pkg::ApbDataW-aadc_pkg::ShiftW){1'b0}}, cfg_q.avg_shift};
        if (wr_en) begin
          cfg_d.avg_shift = pwdata[aadc_pkg::ShiftW-1:0];
        end
      end
      aadc_pkg::REG_DEADBAND_WIDTH: begin
        prdata = {{(aadc_pkg::ApbDataW-aadc_pkg::DbW){1'b0}}, cfg_q.deadband_width};
        if (wr_en) begin
          cfg_d.deadband_width = pwdata[aadc_pkg::DbW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/aadc_in_stage.sv
`default_nettype none

module aadc_in_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [aadc_pkg::TdataW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tuser,
  input  wire logic                         go_i,
  output      logic                         valid_o,
  output      aadc_pkg::item_t              item_o
);

  logic            valid_q, valid_d;
  aadc_pkg::item_t item_q;
  logic            take;

  // Take a new item when empty or when the held one moves on this cycle
  assign s_axis_tready = !valid_q || go_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (go_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.bank    <= s_axis_tuser;
      item_q.channel <= s_axis_tdata[aadc_pkg::ChanW-1:0];
      item_q.sample  <= s_axis_tdata[aadc_pkg::ChanW +: aadc_pkg::SampleW];
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: design/aadc_chan_core.sv
`default_nettype none

module aadc_chan_core #(
  parameter int unsigned ChannelsPerBank = aadc_pkg::CHANNELS_PER_BANK_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire aadc_pkg::item_t  item_i,
  input  wire aadc_pkg::cfg_t   cfg_i,
  output      aadc_pkg::result_t res_o
);

  localparam int unsigned Slots = 2 * ChannelsPerBank;
  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CmpW  = aadc_pkg::ChanW + 1;

  logic [aadc_pkg::SumW-1:0]   sum_q  [Slots];
  logic [aadc_pkg::CountW-1:0] cnt_q  [Slots];
  logic [aadc_pkg::LevelW-1:0] held_q [Slots];

  logic [SlotW-1:0]            slot;
  logic                        in_range;
  logic [aadc_pkg::ShiftW-1:0] shift;
  logic [aadc_pkg::DbW-1:0]    db;
  logic [aadc_pkg::SumW-1:0]   sum_new;
  logic [aadc_pkg::CountW:0]   cnt_inc;
  logic [aadc_pkg::CountW:0]   need;
  logic                        done;
  logic [aadc_pkg::SumW-1:0]   avg;
  logic signed [17:0]          fresh;
  logic signed [17:0]          diff;
  logic signed [17:0]          db_s;
  logic                        exceed;
  logic [aadc_pkg::LevelW-1:0] floored;
  logic [aadc_pkg::LevelW-1:0] level;
  logic [aadc_pkg::LevelW-1:0] held;

  // Clamp the configuration to its working range
  assign shift = (cfg_i.avg_shift > aadc_pkg::SHIFT_MAX) ? aadc_pkg::SHIFT_MAX
                                                         : cfg_i.avg_shift;
  assign db    = (cfg_i.deadband_width > aadc_pkg::DEADBAND_MAX) ? aadc_pkg::DEADBAND_MAX
                                                                 : cfg_i.deadband_width;

  assign in_range = {1'b0, item_i.channel} < CmpW'(ChannelsPerBank);
  assign slot     = item_i.bank ? (SlotW'(ChannelsPerBank) + SlotW'(item_i.channel))
                                : SlotW'(item_i.channel);

  assign held    = held_q[slot];
  assign sum_new = sum_q[slot] + aadc_pkg::SumW'(item_i.sample);
  assign cnt_inc = {1'b0, cnt_q[slot]} + 5'd1;
  assign need    = 5'd1 << shift;
  assign done    = !(cnt_inc < need);

  assign avg     = sum_new >> shift;
  assign fresh   = 18'(aadc_pkg::LEVEL_SCALE) - $signed({2'b00, avg});
  assign diff    = fresh - $signed({6'b0, held});
  assign db_s    = $signed({15'b0, db});
  assign exceed  = (diff > db_s) || (diff < -db_s);
  assign floored = fresh[17] ? '0 : fresh[aadc_pkg::LevelW-1:0];
  assign level   = ((db != '0) && !exceed) ? held : floored;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        sum_q[i]  <= '0;
        cnt_q[i]  <= '0;
        held_q[i] <= '0;
      end
    end else if (fire_i && in_range) begin
      if (done) begin
        sum_q[slot] <= '0;
        cnt_q[slot] <= '0;
        if (db != '0) begin
          held_q[slot] <= level;
        end
      end else begin
        sum_q[slot] <= sum_new;
        cnt_q[slot] <= cnt_inc[aadc_pkg::CountW-1:0];
      end
    end
  end

  assign res_o.valid   = in_range && done;
  assign res_o.bank    = item_i.bank;
  assign res_o.channel = item_i.channel;
  assign res_o.level   = level;

endmodule

`default_nettype wire

// File: design/aadc_out_stage.sv
`default_nettype none

module aadc_out_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire aadc_pkg::result_t            res_i,
  output      logic                         free_o,
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [aadc_pkg::TdataW-1:0]  m_axis_tdata,
  output      logic                         m_axis_tuser
);

  localparam int unsigned PadW = aadc_pkg::TdataW - aadc_pkg::ChanW - aadc_pkg::LevelW;

  logic                        valid_q, valid_d;
  logic                        bank_q;
  logic [aadc_pkg::ChanW-1:0]  chan_q;
  logic [aadc_pkg::LevelW-1:0] level_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bank_q  <= res_i.bank;
      chan_q  <= res_i.channel;
      level_q <= res_i.level;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = bank_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, level_q, chan_q};

endmodule

`default_nettype wire
